>>> rtl/scfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfd_pkg
// Shared types, constants, the CRC-8 byte update and the divide by 65535 of
// the sensor frame decoder.
// ----------------------------------------------------------------------------
package scfd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned TempW    = 15;
  localparam int unsigned HumW     = 14;
  localparam int unsigned SerialW  = 32;
  localparam int unsigned ProdW    = 31;
  localparam int unsigned QuotW    = 15;
  localparam int unsigned WideW    = 16;

  localparam logic [ByteW-1:0] CrcInit     = 8'hFF;
  localparam logic [ByteW-1:0] PolyReset   = 8'h31;

  localparam logic [ProdW-1:0] TempScale   = 31'd17500;
  localparam logic [ProdW-1:0] HumScale    = 31'd12500;
  localparam logic signed [WideW-1:0] TempOffset = -16'sd4500;
  localparam logic signed [WideW-1:0] HumOffset  = -16'sd600;
  localparam logic signed [WideW-1:0] HumMax     = 16'sd10000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPoly = 1'b0,
    CfgKind = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PosW0Hi  = 3'd0,
    PosW0Lo  = 3'd1,
    PosCrc0  = 3'd2,
    PosW1Hi  = 3'd3,
    PosW1Lo  = 3'd4,
    PosCrc1  = 3'd5,
    PosDone  = 3'd6
  } pos_e;

  typedef struct packed {
    logic [WordW-1:0] word0;
    logic [WordW-1:0] word1;
    logic             crc_err;
    logic             serial_mode;
  } frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_beat_t;

  function automatic logic [ByteW-1:0] crc8_feed(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b,
                                                 input logic [ByteW-1:0] poly);
    logic [ByteW-1:0] v;
    v = crc ^ b;
    for (int k = 0; k < ByteW; k++) begin
      if (v[ByteW-1]) begin
        v = {v[ByteW-2:0], 1'b0} ^ poly;
      end else begin
        v = {v[ByteW-2:0], 1'b0};
      end
    end
    return v;
  endfunction

  // floor(p / 65535) for quotients below 2^15
  function automatic logic [QuotW-1:0] div_65535(input logic [ProdW-1:0] p);
    logic [31:0] s;
    s = 32'(p) + 32'(p >> 16) + 32'd1;
    return s[30:16];
  endfunction

endpackage
`default_nettype wire

>>> rtl/scfd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfd_front
// Byte intake: configuration registers, frame position, CRC check and word
// assembly; hands each finished frame to the frame queue.
// ----------------------------------------------------------------------------
module scfd_front (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [scfd_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire logic [scfd_pkg::ByteW-1:0]           cfg_wdata_i,
  input  wire logic                                 accept_i,
  input  wire logic [scfd_pkg::ByteW-1:0]           rx_byte_i,
  input  wire logic                                 frame_start_i,
  output scfd_pkg::frame_beat_t                     beat_o
);

  logic [scfd_pkg::ByteW-1:0] poly_q;
  logic                       kind_q;

  scfd_pkg::pos_e             pos_q, pos_d;
  logic [scfd_pkg::ByteW-1:0] crc_q, crc_d;
  logic [scfd_pkg::WordW-1:0] word0_q, word0_d;
  logic [scfd_pkg::WordW-1:0] word1_q, word1_d;
  logic                       bad_q, bad_d;

  scfd_pkg::pos_e             pos_cur;
  logic [scfd_pkg::ByteW-1:0] crc_cur;
  logic [scfd_pkg::ByteW-1:0] crc_next;
  logic                       bad_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= scfd_pkg::PolyReset;
      kind_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (scfd_pkg::cfg_reg_e'(cfg_idx_i))
        scfd_pkg::CfgPoly: poly_q <= cfg_wdata_i;
        scfd_pkg::CfgKind: kind_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= scfd_pkg::PosW0Hi;
      crc_q   <= scfd_pkg::CrcInit;
      word0_q <= '0;
      word1_q <= '0;
      bad_q   <= 1'b0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      word0_q <= word0_d;
      word1_q <= word1_d;
      bad_q   <= bad_d;
    end
  end

  always_comb begin
    pos_cur  = frame_start_i ? scfd_pkg::PosW0Hi : pos_q;
    crc_cur  = frame_start_i ? scfd_pkg::CrcInit : crc_q;
    bad_cur  = frame_start_i ? 1'b0 : bad_q;
    crc_next = scfd_pkg::crc8_feed(crc_cur, rx_byte_i, poly_q);

    pos_d   = pos_cur;
    crc_d   = crc_cur;
    word0_d = word0_q;
    word1_d = word1_q;
    bad_d   = bad_cur;

    beat_o.valid             = 1'b0;
    beat_o.frame.word0       = word0_q;
    beat_o.frame.word1       = word1_q;
    beat_o.frame.crc_err     = bad_cur | (crc_cur != rx_byte_i);
    beat_o.frame.serial_mode = kind_q;

    case (pos_cur)
      scfd_pkg::PosW0Hi: begin
        word0_d = {rx_byte_i, word0_q[7:0]};
        crc_d   = crc_next;
        pos_d   = scfd_pkg::PosW0Lo;
      end
      scfd_pkg::PosW0Lo: begin
        word0_d = {word0_q[15:8], rx_byte_i};
        crc_d   = crc_next;
        pos_d   = scfd_pkg::PosCrc0;
      end
      scfd_pkg::PosCrc0: begin
        bad_d = (crc_cur != rx_byte_i);
        crc_d = scfd_pkg::CrcInit;
        pos_d = scfd_pkg::PosW1Hi;
      end
      scfd_pkg::PosW1Hi: begin
        word1_d = {rx_byte_i, word1_q[7:0]};
        crc_d   = crc_next;
        pos_d   = scfd_pkg::PosW1Lo;
      end
      scfd_pkg::PosW1Lo: begin
        word1_d = {word1_q[15:8], rx_byte_i};
        crc_d   = crc_next;
        pos_d   = scfd_pkg::PosCrc1;
      end
      scfd_pkg::PosCrc1: begin
        crc_d        = scfd_pkg::CrcInit;
        pos_d        = scfd_pkg::PosDone;
        beat_o.valid = accept_i;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/scfd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfd_fifo
// Two-entry queue of finished frames between intake and conversion.
// ----------------------------------------------------------------------------
module scfd_fifo (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire scfd_pkg::frame_beat_t wr_i,
  input  wire logic                  rd_en_i,
  output logic                       full_o,
  output logic                       empty_o,
  output scfd_pkg::frame_t           rd_data_o
);

  scfd_pkg::frame_t mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_wr;
  logic             do_rd;

  assign full_o    = count_q[1];
  assign empty_o   = (count_q == 2'd0);
  assign do_wr     = wr_i.valid && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_i.frame;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_q <= ~wr_ptr_q;
      if (do_rd) rd_ptr_q <= ~rd_ptr_q;
      case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/scfd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfd_back
// Frame conversion: scaling multiply, divide by full scale, offset, clamp
// and the result register; serial mode passes the two words as serial number.
// ----------------------------------------------------------------------------
module scfd_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                q_empty_i,
  input  wire scfd_pkg::frame_t                    q_data_i,
  output logic                                     q_rd_o,
  input  wire logic                                pop_i,
  output logic                                     empty_o,
  output logic signed [scfd_pkg::TempW-1:0]        temperature_centi_o,
  output logic [scfd_pkg::HumW-1:0]                humidity_centi_o,
  output logic                                     humidity_clamped_o,
  output logic [scfd_pkg::SerialW-1:0]             serial_number_o,
  output logic                                     crc_error_o
);

  logic                        a_valid_q;
  logic [scfd_pkg::ProdW-1:0]  t_prod_q;
  logic [scfd_pkg::ProdW-1:0]  h_prod_q;
  scfd_pkg::frame_t            a_frame_q;

  logic                        out_valid_q;
  logic signed [scfd_pkg::TempW-1:0] temp_q, temp_d;
  logic [scfd_pkg::HumW-1:0]   hum_q, hum_d;
  logic                        clamp_q, clamp_d;
  logic [scfd_pkg::SerialW-1:0] serial_q, serial_d;
  logic                        err_q;

  logic                        out_ready;
  logic                        a_ready;
  logic signed [scfd_pkg::WideW-1:0] t_wide;
  logic signed [scfd_pkg::WideW-1:0] h_wide;

  assign out_ready = !out_valid_q || pop_i;
  assign a_ready   = !a_valid_q || out_ready;
  assign q_rd_o    = a_ready && !q_empty_i;

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      t_prod_q  <= scfd_pkg::ProdW'(q_data_i.word0) * scfd_pkg::TempScale;
      h_prod_q  <= scfd_pkg::ProdW'(q_data_i.word1) * scfd_pkg::HumScale;
      a_frame_q <= q_data_i;
    end
  end

  always_comb begin
    t_wide = $signed({1'b0, scfd_pkg::div_65535(t_prod_q)}) + scfd_pkg::TempOffset;
    h_wide = $signed({1'b0, scfd_pkg::div_65535(h_prod_q)}) + scfd_pkg::HumOffset;
    temp_d   = t_wide[scfd_pkg::TempW-1:0];
    hum_d    = h_wide[scfd_pkg::HumW-1:0];
    clamp_d  = 1'b0;
    serial_d = '0;
    if (h_wide < 0) begin
      hum_d   = '0;
      clamp_d = 1'b1;
    end else if (h_wide > scfd_pkg::HumMax) begin
      hum_d   = scfd_pkg::HumMax[scfd_pkg::HumW-1:0];
      clamp_d = 1'b1;
    end
    if (a_frame_q.serial_mode) begin
      temp_d   = '0;
      hum_d    = '0;
      clamp_d  = 1'b0;
      serial_d = {a_frame_q.word0, a_frame_q.word1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && out_ready) begin
      temp_q   <= temp_d;
      hum_q    <= hum_d;
      clamp_q  <= clamp_d;
      serial_q <= serial_d;
      err_q    <= a_frame_q.crc_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= !q_empty_i;
      if (out_ready) out_valid_q <= a_valid_q;
    end
  end

  assign empty_o             = !out_valid_q;
  assign temperature_centi_o = temp_q;
  assign humidity_centi_o    = hum_q;
  assign humidity_clamped_o  = clamp_q;
  assign serial_number_o     = serial_q;
  assign crc_error_o         = err_q;

`ifndef SYNTHESIS
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |=> out_valid_q && $stable(temp_q) && $stable(serial_q))
    else $error("result changed while stalled");
  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> hum_q <= scfd_pkg::HumMax[scfd_pkg::HumW-1:0])
    else $error("humidity above full scale");
  a_mode_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (serial_q != '0) |-> (temp_q == '0) && (hum_q == '0) && !clamp_q)
    else $error("measurement fields set in serial mode");
  a_no_read_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && out_valid_q && !pop_i |-> !q_rd_o)
    else $error("queue read while conversion stage is blocked");
`endif

endmodule
`default_nettype wire

>>> rtl/sensor_frame_crc_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_frame_crc_decoder
// Decodes six-byte humidity/temperature sensor frames with CRC-8 checks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive rx_byte_i/frame_start_i with push_i; a byte beat is
//   taken at an edge with push_i high and full_o low. One byte per cycle.
//   frame_start_i restarts the frame at the byte it comes with; bytes after
//   the sixth are dropped until the next frame_start_i.
//   Result channel: one result per frame, on the ports while empty_o is low,
//   taken at an edge with pop_i high. After the sixth byte, the frame passes
//   through the frame queue, the multiply stage and then the result register.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 =
//   polynomial, 1 = frame kind); users must write only while idle, unchecked.
//   Stall: a two-frame queue sits between intake and conversion; while pop_i
//   is low the result holds, and full_o rises only when both queue slots are
//   taken.
//   Reset: polynomial 0x31, measurement mode, position at the first byte,
//   queue and result empty.
// ----------------------------------------------------------------------------
module sensor_frame_crc_decoder (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [scfd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [scfd_pkg::ByteW-1:0]          cfg_wdata_i,
  input  wire logic                                push_i,
  output logic                                     full_o,
  input  wire logic [scfd_pkg::ByteW-1:0]          rx_byte_i,
  input  wire logic                                frame_start_i,
  output logic                                     empty_o,
  input  wire logic                                pop_i,
  output logic signed [scfd_pkg::TempW-1:0]        temperature_centi_o,
  output logic [scfd_pkg::HumW-1:0]                humidity_centi_o,
  output logic                                     humidity_clamped_o,
  output logic [scfd_pkg::SerialW-1:0]             serial_number_o,
  output logic                                     crc_error_o
);

  scfd_pkg::frame_beat_t front_beat;
  scfd_pkg::frame_t      q_data;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_rd;
  logic                  accept;

  assign full_o = q_full;
  assign accept = push_i && !q_full;

  scfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .beat_o        (front_beat)
  );

  scfd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_beat),
    .rd_en_i   (q_rd),
    .full_o    (q_full),
    .empty_o   (q_empty),
    .rd_data_o (q_data)
  );

  scfd_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_empty_i           (q_empty),
    .q_data_i            (q_data),
    .q_rd_o              (q_rd),
    .pop_i               (pop_i),
    .empty_o             (empty_o),
    .temperature_centi_o (temperature_centi_o),
    .humidity_centi_o    (humidity_centi_o),
    .humidity_clamped_o  (humidity_clamped_o),
    .serial_number_o     (serial_number_o),
    .crc_error_o         (crc_error_o)
  );

endmodule
`default_nettype wire
